[hdl/iftc_pkg.sv]
// ----------------------------------------------------------------------------
// iftc_pkg
// Shared constants, register indexes and controller/datapath types for the
// IoU face track counter.
// ----------------------------------------------------------------------------
package iftc_pkg;

  // default sizes, handed to the top level parameters
  localparam int COORD_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF = 16;
  localparam int AGE_GROUPS_DEF = 5;

  // fixed field widths
  localparam int VOTE_BITS     = 16;
  localparam int OUT_BITS      = 16;
  localparam int AGE_IN_BITS   = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IOU_TENTHS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MISS_LIMIT = 2'd1;

  // register reset values
  localparam logic [CFG_DATA_BITS-1:0] IOU_TENTHS_RST = 4'd3;
  localparam logic [CFG_DATA_BITS-1:0] MISS_LIMIT_RST = 4'd1;

  // controller to datapath commands, one step of the sequence each
  typedef struct packed {
    logic load_item;
    logic calc_area;
    logic upd_best;
    logic calc_ovl;
    logic calc_ov;
    logic calc_uni;
    logic calc_cmp;
    logic calc_maj;
    logic frame_upd;
  } iftc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic item_eof;
  } iftc_sts_t;

  // result payload
  typedef struct packed {
    logic [OUT_BITS-1:0] people_total;
    logic [OUT_BITS-1:0] gender0_total;
    logic [OUT_BITS-1:0] gender1_total;
    logic [OUT_BITS-1:0] age0_total;
    logic [OUT_BITS-1:0] age1_total;
    logic [OUT_BITS-1:0] age2_total;
    logic [OUT_BITS-1:0] age3_total;
    logic [OUT_BITS-1:0] age4_total;
    logic                tracking;
  } iftc_res_t;

endpackage

[hdl/iftc_in_if.sv]
// ----------------------------------------------------------------------------
// iftc_in_if
// Face item channel: valid/ready handshake with one detected face per transfer.
// ----------------------------------------------------------------------------
interface iftc_in_if import iftc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   face_valid;
  logic                   end_of_frame;
  logic [COORD_BITS-1:0]  box_left;
  logic [COORD_BITS-1:0]  box_top;
  logic [COORD_BITS-1:0]  box_right;
  logic [COORD_BITS-1:0]  box_bottom;
  logic                   gender_class;
  logic [AGE_IN_BITS-1:0] age_class;

  modport source (
    output valid, face_valid, end_of_frame, box_left, box_top, box_right,
           box_bottom, gender_class, age_class,
    input  ready
  );
  modport sink (
    input  valid, face_valid, end_of_frame, box_left, box_top, box_right,
           box_bottom, gender_class, age_class,
    output ready
  );
endinterface

[hdl/iftc_out_if.sv]
// ----------------------------------------------------------------------------
// iftc_out_if
// Result channel: counter totals and track flag, one transfer per frame.
// ----------------------------------------------------------------------------
interface iftc_out_if import iftc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] people_total;
  logic [OUT_BITS-1:0] gender0_total;
  logic [OUT_BITS-1:0] gender1_total;
  logic [OUT_BITS-1:0] age0_total;
  logic [OUT_BITS-1:0] age1_total;
  logic [OUT_BITS-1:0] age2_total;
  logic [OUT_BITS-1:0] age3_total;
  logic [OUT_BITS-1:0] age4_total;
  logic                tracking;

  modport source (
    output valid, people_total, gender0_total, gender1_total, age0_total,
           age1_total, age2_total, age3_total, age4_total, tracking,
    input  ready
  );
  modport sink (
    input  valid, people_total, gender0_total, gender1_total, age0_total,
           age1_total, age2_total, age3_total, age4_total, tracking,
    output ready
  );
endinterface

[hdl/iftc_cfg_if.sv]
// ----------------------------------------------------------------------------
// iftc_cfg_if
// Configuration write channel: register index and data per transfer.
// ----------------------------------------------------------------------------
interface iftc_cfg_if import iftc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/iftc_ctrl.sv]
// ----------------------------------------------------------------------------
// iftc_ctrl
// Sequencer for the face tracker: walks each item through area and best-face,
// end-of-frame items on to IoU, majority and frame update; owns result valid.
// ----------------------------------------------------------------------------
module iftc_ctrl import iftc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  iftc_sts_t sts,
  output iftc_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AREA = 4'd1;
  localparam logic [3:0] S_BEST = 4'd2;
  localparam logic [3:0] S_OVL  = 4'd3;
  localparam logic [3:0] S_OV   = 4'd4;
  localparam logic [3:0] S_UNI  = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_MAJ  = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  // result slot can take a new frame result this cycle
  assign slot_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_AREA;
        end
      end
      S_AREA: begin
        cmd.calc_area = 1'b1;
        state_nxt     = S_BEST;
      end
      S_BEST: begin
        cmd.upd_best = 1'b1;
        state_nxt    = sts.item_eof ? S_OVL : S_IDLE;
      end
      S_OVL: begin
        cmd.calc_ovl = 1'b1;
        state_nxt    = S_OV;
      end
      S_OV: begin
        cmd.calc_ov = 1'b1;
        state_nxt   = S_UNI;
      end
      S_UNI: begin
        cmd.calc_uni = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        cmd.calc_cmp = 1'b1;
        state_nxt    = S_MAJ;
      end
      S_MAJ: begin
        cmd.calc_maj = 1'b1;
        state_nxt    = S_UPD;
      end
      S_UPD: begin
        if (slot_free) begin
          cmd.frame_upd = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid: set by the frame update, cleared by a transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.frame_upd) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a frame update never overwrites a result that is still waiting
  a_upd_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.frame_upd |-> (!out_valid_r || out_ready))
    else $error("frame update while result slot busy");

  // at most one step runs per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command");

  // an accepted item always starts the area step next
  a_accept_area: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_AREA))
    else $error("accepted item did not start the area step");

  // a new result appears only from a frame update
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.frame_upd))
    else $error("result valid without frame update");

endmodule

[hdl/iftc_dp.sv]
// ----------------------------------------------------------------------------
// iftc_dp
// Datapath for the face tracker: item and best-face registers, the IoU
// arithmetic (one multiply per step), vote and people counters.
// ----------------------------------------------------------------------------
module iftc_dp import iftc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int AGE_GROUPS = AGE_GROUPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  iftc_cmd_t                cmd,
  output iftc_sts_t                sts,
  input  logic                     face_valid,
  input  logic                     end_of_frame,
  input  logic [COORD_BITS-1:0]    box_left,
  input  logic [COORD_BITS-1:0]    box_top,
  input  logic [COORD_BITS-1:0]    box_right,
  input  logic [COORD_BITS-1:0]    box_bottom,
  input  logic                     gender_class,
  input  logic [AGE_IN_BITS-1:0]   age_class,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output iftc_res_t                res
);

  localparam int AW     = $clog2(AGE_GROUPS);
  localparam int AB     = 2 * COORD_BITS;
  localparam int UB     = AB + 1;
  localparam int LB     = AB + 4;
  localparam int CB     = AB + 5;
  localparam int N_CNT  = 3 + AGE_GROUPS;

  // configuration
  logic [CFG_DATA_BITS-1:0] iou_tenths_r;
  logic [CFG_DATA_BITS-1:0] miss_limit_r;

  // latched item
  logic                  it_face_r, it_eof_r, it_gender_r;
  logic [AW-1:0]         it_age_r;
  logic [COORD_BITS-1:0] it_l_r, it_t_r, it_rt_r, it_b_r;
  logic [AB-1:0]         it_area_r;

  // best face of the frame
  logic                  best_found_r, best_gender_r;
  logic [AW-1:0]         best_age_r;
  logic [COORD_BITS-1:0] best_l_r, best_t_r, best_rt_r, best_b_r;
  logic [AB-1:0]         best_area_r;

  // track
  logic                  active_r;
  logic [CFG_DATA_BITS-1:0] miss_r;
  logic [COORD_BITS-1:0] trk_l_r, trk_t_r, trk_rt_r, trk_b_r;
  logic [VOTE_BITS-1:0]  gvote_r [2];
  logic [VOTE_BITS-1:0]  avote_r [AGE_GROUPS];
  logic [COUNT_BITS-1:0] cnt_r [N_CNT];

  // IoU pipeline registers
  logic [COORD_BITS-1:0] iw_r, ih_r;
  logic [AB-1:0]         ta_r, ov_r;
  logic [UB-1:0]         uni_r;
  logic [LB-1:0]         lhs_r;
  logic                  match_r;
  logic                  maj_g_r;
  logic [AW-1:0]         maj_a_r;

  // combinational helpers
  logic [AW-1:0]         age_c;
  logic [COORD_BITS-1:0] it_w, it_h, trk_w, trk_h;
  logic [COORD_BITS-1:0] x0, x1, y0, y1;
  logic [AW-1:0]         a_idx;
  logic                  do_start, do_miss, do_drop, do_keep, do_repl;
  logic                  do_count, do_fresh, do_track;

  assign sts.item_eof = it_eof_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iou_tenths_r <= IOU_TENTHS_RST;
      miss_limit_r <= MISS_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IOU_TENTHS: iou_tenths_r <= cfg_data;
        REG_MISS_LIMIT: miss_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // age class clamped to the last group
  assign age_c = ({1'b0, age_class} < (AGE_IN_BITS + 1)'(AGE_GROUPS)) ?
                 AW'(age_class) : AW'(AGE_GROUPS - 1);

  // box extents, inverted extents count as zero
  assign it_w  = (it_rt_r > it_l_r) ? it_rt_r - it_l_r : '0;
  assign it_h  = (it_b_r > it_t_r) ? it_b_r - it_t_r : '0;
  assign trk_w = (trk_rt_r > trk_l_r) ? trk_rt_r - trk_l_r : '0;
  assign trk_h = (trk_b_r > trk_t_r) ? trk_b_r - trk_t_r : '0;

  // intersection corners
  assign x0 = (best_l_r > trk_l_r) ? best_l_r : trk_l_r;
  assign y0 = (best_t_r > trk_t_r) ? best_t_r : trk_t_r;
  assign x1 = (best_rt_r < trk_rt_r) ? best_rt_r : trk_rt_r;
  assign y1 = (best_b_r < trk_b_r) ? best_b_r : trk_b_r;

  // item latch and area
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_face_r   <= face_valid;
      it_eof_r    <= end_of_frame;
      it_gender_r <= gender_class;
      it_age_r    <= age_c;
      it_l_r      <= box_left;
      it_t_r      <= box_top;
      it_rt_r     <= box_right;
      it_b_r      <= box_bottom;
    end
    if (cmd.calc_area) begin
      it_area_r <= it_w * it_h;
    end
  end

  // IoU steps: extents and track area, overlap, union, compare
  always_ff @(posedge clk) begin
    if (cmd.calc_ovl) begin
      iw_r <= (x1 > x0) ? x1 - x0 : '0;
      ih_r <= (y1 > y0) ? y1 - y0 : '0;
      ta_r <= trk_w * trk_h;
    end
    if (cmd.calc_ov) begin
      ov_r <= iw_r * ih_r;
    end
    if (cmd.calc_uni) begin
      uni_r <= UB'(ta_r) + UB'(best_area_r) - UB'(ov_r);
      lhs_r <= (LB'(ov_r) << 3) + (LB'(ov_r) << 1);
    end
    if (cmd.calc_cmp) begin
      match_r <= CB'(lhs_r) > (CB'(iou_tenths_r) * CB'(uni_r));
    end
  end

  // majority age: lowest group wins a tie
  always_comb begin
    a_idx = '0;
    for (int i = 1; i < AGE_GROUPS; i++) begin
      if (avote_r[i] > avote_r[a_idx]) begin
        a_idx = AW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_maj) begin
      maj_g_r <= !(gvote_r[0] > gvote_r[1]);
      maj_a_r <= a_idx;
    end
  end

  // frame update decode
  assign do_start = cmd.frame_upd && !active_r && best_found_r;
  assign do_miss  = cmd.frame_upd && active_r && !best_found_r &&
                    (miss_r < miss_limit_r);
  assign do_drop  = cmd.frame_upd && active_r && !best_found_r &&
                    !(miss_r < miss_limit_r);
  assign do_keep  = cmd.frame_upd && active_r && best_found_r && match_r;
  assign do_repl  = cmd.frame_upd && active_r && best_found_r && !match_r;
  assign do_count = do_drop || do_repl;
  assign do_fresh = do_start || do_repl;
  assign do_track = do_fresh || do_keep;

  // best face of the frame; first face wins ties, cleared at end of frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (cmd.frame_upd) begin
      best_found_r <= 1'b0;
    end else if (cmd.upd_best && it_face_r &&
                 (!best_found_r || it_area_r > best_area_r)) begin
      best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_best && it_face_r && (!best_found_r || it_area_r > best_area_r)) begin
      best_l_r      <= it_l_r;
      best_t_r      <= it_t_r;
      best_rt_r     <= it_rt_r;
      best_b_r      <= it_b_r;
      best_area_r   <= it_area_r;
      best_gender_r <= it_gender_r;
      best_age_r    <= it_age_r;
    end
  end

  // track state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      miss_r   <= '0;
    end else begin
      if (do_start) begin
        active_r <= 1'b1;
      end else if (do_drop) begin
        active_r <= 1'b0;
      end
      if (do_miss) begin
        miss_r <= miss_r + 1'b1;
      end else if (do_track || do_drop) begin
        miss_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_track) begin
      trk_l_r  <= best_l_r;
      trk_t_r  <= best_t_r;
      trk_rt_r <= best_rt_r;
      trk_b_r  <= best_b_r;
    end
  end

  // votes: fresh track starts at one vote, a match adds one, a drop clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < 2; g++) gvote_r[g] <= '0;
      for (int a = 0; a < AGE_GROUPS; a++) avote_r[a] <= '0;
    end else begin
      for (int g = 0; g < 2; g++) begin
        if (do_fresh) begin
          gvote_r[g] <= (g == int'(best_gender_r)) ? VOTE_BITS'(1) : '0;
        end else if (do_keep && g == int'(best_gender_r) && gvote_r[g] != '1) begin
          gvote_r[g] <= gvote_r[g] + 1'b1;
        end else if (do_drop) begin
          gvote_r[g] <= '0;
        end
      end
      for (int a = 0; a < AGE_GROUPS; a++) begin
        if (do_fresh) begin
          avote_r[a] <= (a == int'(best_age_r)) ? VOTE_BITS'(1) : '0;
        end else if (do_keep && a == int'(best_age_r) && avote_r[a] != '1) begin
          avote_r[a] <= avote_r[a] + 1'b1;
        end else if (do_drop) begin
          avote_r[a] <= '0;
        end
      end
    end
  end

  // people counters: total, majority gender, majority age; saturating
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_CNT; i++) cnt_r[i] <= '0;
    end else if (do_count) begin
      for (int i = 0; i < N_CNT; i++) begin
        if ((i == 0 || i == 1 + int'(maj_g_r) || i == 3 + int'(maj_a_r)) &&
            cnt_r[i] != '1) begin
          cnt_r[i] <= cnt_r[i] + 1'b1;
        end
      end
    end
  end

  // result fields: low bits of each counter, missing age groups read zero
  logic [OUT_BITS-1:0] age_tot [5];

  for (genvar j = 0; j < 5; j++) begin : g_age_out
    if (j < AGE_GROUPS) begin : g_have
      logic [31:0] ext;
      assign ext        = 32'(cnt_r[3 + j]);
      assign age_tot[j] = ext[OUT_BITS-1:0];
    end else begin : g_none
      assign age_tot[j] = '0;
    end
  end

  logic [31:0] ext_p, ext_g0, ext_g1;
  assign ext_p  = 32'(cnt_r[0]);
  assign ext_g0 = 32'(cnt_r[1]);
  assign ext_g1 = 32'(cnt_r[2]);

  assign res.people_total  = ext_p[OUT_BITS-1:0];
  assign res.gender0_total = ext_g0[OUT_BITS-1:0];
  assign res.gender1_total = ext_g1[OUT_BITS-1:0];
  assign res.age0_total    = age_tot[0];
  assign res.age1_total    = age_tot[1];
  assign res.age2_total    = age_tot[2];
  assign res.age3_total    = age_tot[3];
  assign res.age4_total    = age_tot[4];
  assign res.tracking      = active_r;

  // an active track always holds at least one gender vote
  a_track_votes: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (gvote_r[0] != '0 || gvote_r[1] != '0))
    else $error("active track without votes");

  // a dropped track leaves no votes behind
  a_drop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    do_drop |=> (!active_r && gvote_r[0] == '0 && gvote_r[1] == '0))
    else $error("votes left after track drop");

  // the best face is gone after every frame update
  a_best_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.frame_upd |=> !best_found_r)
    else $error("best face kept across frames");

endmodule

[hdl/iou_face_track_counter.sv]
// ----------------------------------------------------------------------------
// iou_face_track_counter
// Keeps the largest face of each frame, matches it to one tracked face by IoU
// and counts finished tracks by majority gender and age.
// ----------------------------------------------------------------------------
// Sequence: an item without end_of_frame passes accept, area multiply and
//   best-face compare; an end_of_frame item goes on through the IoU steps.
//   A new item is accepted only once the previous one has finished.
// Result: valid is registered from the frame update, after the datapath's
//   one-multiply-per-step IoU steps; that update waits for a free result slot.
// Reset: synchronous, active low; clears best face, track, votes and counters,
//   loads iou_tenths=3 and miss_limit=1. No clearing pass.
module iou_face_track_counter import iftc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int AGE_GROUPS = AGE_GROUPS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  iftc_in_if.sink    in_ch,
  iftc_out_if.source out_ch,
  iftc_cfg_if.sink   cfg_ch
);

  iftc_cmd_t cmd;
  iftc_sts_t sts;
  iftc_res_t res;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  iftc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iftc_dp #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS),
    .AGE_GROUPS (AGE_GROUPS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .face_valid   (in_ch.face_valid),
    .end_of_frame (in_ch.end_of_frame),
    .box_left     (in_ch.box_left),
    .box_top      (in_ch.box_top),
    .box_right    (in_ch.box_right),
    .box_bottom   (in_ch.box_bottom),
    .gender_class (in_ch.gender_class),
    .age_class    (in_ch.age_class),
    .cfg_we       (cfg_ch.valid),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .res          (res)
  );

  // result payload
  assign out_ch.people_total  = res.people_total;
  assign out_ch.gender0_total = res.gender0_total;
  assign out_ch.gender1_total = res.gender1_total;
  assign out_ch.age0_total    = res.age0_total;
  assign out_ch.age1_total    = res.age1_total;
  assign out_ch.age2_total    = res.age2_total;
  assign out_ch.age3_total    = res.age3_total;
  assign out_ch.age4_total    = res.age4_total;
  assign out_ch.tracking      = res.tracking;

endmodule

[tb/sv/iou_face_track_counter_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_face_track_counter_check
// Watches the face, result and register channels of the face track counter.
// It keeps its own copy of the best face, the track and the counters, works
// out the totals each end-of-frame transfer should produce, and compares
// every result transfer with the oldest one waiting.
// ----------------------------------------------------------------------------
module iou_face_track_counter_check import iftc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  iftc_in_if   in_ch,
  iftc_out_if  out_ch,
  iftc_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);

  localparam int CW   = COORD_BITS_DEF;
  localparam int AG   = AGE_GROUPS_DEF;
  localparam int NCNT = 3 + AG;

  typedef struct packed {
    logic [CW-1:0] l;
    logic [CW-1:0] t;
    logic [CW-1:0] r;
    logic [CW-1:0] b;
  } box_t;

  // register copies
  logic [CFG_DATA_BITS-1:0] iou_th;
  logic [CFG_DATA_BITS-1:0] miss_lim;

  // best face of the current frame
  logic                   best_found;
  box_t                   best_box;
  logic [63:0]            best_area;
  logic                   best_gender;
  logic [AGE_IN_BITS-1:0] best_age;

  // tracked face and its votes
  logic                     trk_active;
  logic [CFG_DATA_BITS-1:0] miss_cnt;
  box_t                     trk_box;
  logic [VOTE_BITS-1:0]     gender_votes [2];
  logic [VOTE_BITS-1:0]     age_votes [AG];
  logic [COUNT_BITS_DEF-1:0] people_cnt [NCNT];

  // totals still owed by the block, oldest first
  iftc_res_t totals_q [$];

  function automatic logic [63:0] extent(logic [CW-1:0] lo, logic [CW-1:0] hi);
    logic [63:0] d;
    d = '0;
    if (hi > lo) d = hi - lo;
    return d;
  endfunction

  function automatic logic [63:0] area_of(box_t bx);
    return extent(bx.l, bx.r) * extent(bx.t, bx.b);
  endfunction

  // overlap*10 > tenths*union, all in integers
  function automatic bit iou_match(box_t p, box_t q, logic [CFG_DATA_BITS-1:0] th);
    logic [63:0] x0, y0, x1, y1, ov, uni, thw;
    x0 = (p.l > q.l) ? p.l : q.l;
    y0 = (p.t > q.t) ? p.t : q.t;
    x1 = (p.r < q.r) ? p.r : q.r;
    y1 = (p.b < q.b) ? p.b : q.b;
    ov = '0;
    if (x0 < x1 && y0 < y1) ov = (x1 - x0) * (y1 - y0);
    uni = area_of(p) + area_of(q) - ov;
    thw = th;
    return (ov * 10) > (thw * uni);
  endfunction

  // votes and counters are both 16 bits here and stick at all ones
  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function void clear_votes();
    foreach (gender_votes[i]) gender_votes[i] = '0;
    foreach (age_votes[i]) age_votes[i] = '0;
  endfunction

  function void add_face_vote();
    gender_votes[best_gender] = sat_inc(gender_votes[best_gender]);
    age_votes[best_age]       = sat_inc(age_votes[best_age]);
    trk_box  = best_box;
    miss_cnt = '0;
  endfunction

  // count a finished track by majority; gender tie goes to 1, age tie to lowest
  function void tally_track();
    int g, a;
    g = (gender_votes[0] > gender_votes[1]) ? 0 : 1;
    a = 0;
    for (int i = 1; i < AG; i++)
      if (age_votes[i] > age_votes[a]) a = i;
    people_cnt[0]     = sat_inc(people_cnt[0]);
    people_cnt[1 + g] = sat_inc(people_cnt[1 + g]);
    people_cnt[3 + a] = sat_inc(people_cnt[3 + a]);
  endfunction

  function void update_track();
    if (!trk_active) begin
      if (best_found) begin
        trk_active = 1'b1;
        clear_votes();
        add_face_vote();
      end
    end else if (!best_found) begin
      if (miss_cnt < miss_lim) begin
        miss_cnt = miss_cnt + 1'b1;
      end else begin
        tally_track();
        trk_active = 1'b0;
        miss_cnt   = '0;
        clear_votes();
        trk_box    = '0;
      end
    end else if (iou_match(trk_box, best_box, iou_th)) begin
      add_face_vote();
    end else begin
      tally_track();
      clear_votes();
      add_face_vote();
    end
  endfunction

  function void take_face(logic fv, logic eof, box_t bx, logic g, logic [AGE_IN_BITS-1:0] a);
    logic [63:0] ar;
    iftc_res_t   res;
    // largest face of the frame, earlier face wins a tie
    if (fv) begin
      ar = area_of(bx);
      if (!best_found || ar > best_area) begin
        best_found  = 1'b1;
        best_box    = bx;
        best_area   = ar;
        best_gender = g;
        best_age    = (a < AG) ? a : AGE_IN_BITS'(AG - 1);
      end
    end
    if (eof) begin
      update_track();
      best_found  = 1'b0;
      best_box    = '0;
      best_area   = '0;
      best_gender = 1'b0;
      best_age    = '0;
      res.people_total  = people_cnt[0][OUT_BITS-1:0];
      res.gender0_total = people_cnt[1][OUT_BITS-1:0];
      res.gender1_total = people_cnt[2][OUT_BITS-1:0];
      res.age0_total    = people_cnt[3][OUT_BITS-1:0];
      res.age1_total    = people_cnt[4][OUT_BITS-1:0];
      res.age2_total    = people_cnt[5][OUT_BITS-1:0];
      res.age3_total    = people_cnt[6][OUT_BITS-1:0];
      res.age4_total    = people_cnt[7][OUT_BITS-1:0];
      res.tracking      = trk_active;
      totals_q.push_back(res);
    end
  endfunction

  function void check_field(string name, logic [OUT_BITS-1:0] want, logic [OUT_BITS-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // all three channels sampled at the rising edge
  always @(posedge clk) begin
    iftc_res_t want;
    box_t      bx;
    if (!rst_n) begin
      iou_th      = IOU_TENTHS_RST;
      miss_lim    = MISS_LIMIT_RST;
      best_found  = 1'b0;
      best_box    = '0;
      best_area   = '0;
      best_gender = 1'b0;
      best_age    = '0;
      trk_active  = 1'b0;
      miss_cnt    = '0;
      trk_box     = '0;
      clear_votes();
      foreach (people_cnt[i]) people_cnt[i] = '0;
      totals_q.delete();
      fail_count  = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_IOU_TENTHS: iou_th = cfg_ch.data;
          REG_MISS_LIMIT: miss_lim = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (totals_q.size() == 0) begin
          $error("result transfer with no result expected");
          fail_count++;
        end else begin
          want = totals_q.pop_front();
          check_field("people_total", want.people_total, out_ch.people_total);
          check_field("gender0_total", want.gender0_total, out_ch.gender0_total);
          check_field("gender1_total", want.gender1_total, out_ch.gender1_total);
          check_field("age0_total", want.age0_total, out_ch.age0_total);
          check_field("age1_total", want.age1_total, out_ch.age1_total);
          check_field("age2_total", want.age2_total, out_ch.age2_total);
          check_field("age3_total", want.age3_total, out_ch.age3_total);
          check_field("age4_total", want.age4_total, out_ch.age4_total);
          check_field("tracking", want.tracking, out_ch.tracking);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        bx.l = in_ch.box_left;
        bx.t = in_ch.box_top;
        bx.r = in_ch.box_right;
        bx.b = in_ch.box_bottom;
        take_face(in_ch.face_valid, in_ch.end_of_frame, bx, in_ch.gender_class,
                  in_ch.age_class);
      end
    end
    pending = totals_q.size();
  end

endmodule

[tb/sv/iou_face_track_counter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_face_track_counter_test
// Drives face items and register writes into the face track counter. A short
// directed frame sequence comes first, then random frames built around a
// drifting face so tracks live, match, get replaced and time out, under
// several threshold and miss settings and several idle/stall patterns.
// ----------------------------------------------------------------------------
module iou_face_track_counter_test;
  import iftc_pkg::*;

  localparam int CMAX         = (1 << COORD_BITS_DEF) - 1;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASES       = 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int TAIL_CYCLES  = 12;

  typedef struct packed {
    logic                   face_valid;
    logic                   end_of_frame;
    logic [COORD_BITS_DEF-1:0] left_x;
    logic [COORD_BITS_DEF-1:0] top_y;
    logic [COORD_BITS_DEF-1:0] right_x;
    logic [COORD_BITS_DEF-1:0] bottom_y;
    logic                   gender;
    logic [AGE_IN_BITS-1:0] age;
  } face_item_t;

  logic clk;
  logic rst_n;
  int   cycle_cnt = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  int   fail_count;
  int   pending;
  int   sent;
  int   cur_miss;
  int   anc_l, anc_t, anc_w, anc_h, anc_g, anc_a;

  iftc_in_if #(.COORD_BITS(COORD_BITS_DEF)) in_ch ();
  iftc_out_if out_ch ();
  iftc_cfg_if cfg_ch ();

  iou_face_track_counter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  iou_face_track_counter_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("iou_face_track_counter_test failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic int clamp(int v);
    return (v < 0) ? 0 : (v > CMAX) ? CMAX : v;
  endfunction

  function automatic face_item_t make_face(logic fv, logic eof, int l, int t, int r, int b,
                                           int g, int a);
    face_item_t f;
    f.face_valid   = fv;
    f.end_of_frame = eof;
    f.left_x       = COORD_BITS_DEF'(clamp(l));
    f.top_y        = COORD_BITS_DEF'(clamp(t));
    f.right_x      = COORD_BITS_DEF'(clamp(r));
    f.bottom_y     = COORD_BITS_DEF'(clamp(b));
    f.gender       = g[0];
    f.age          = a[AGE_IN_BITS-1:0];
    return f;
  endfunction

  // every field random, boxes may come out inverted
  function automatic face_item_t random_face(logic fv, logic eof);
    return make_face(fv, eof, $urandom_range(CMAX), $urandom_range(CMAX),
                     $urandom_range(CMAX), $urandom_range(CMAX),
                     $urandom_range(1), $urandom_range(7));
  endfunction

  // one transfer on the face channel; valid stays up for a following item
  task automatic send_face(face_item_t f);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.face_valid   <= f.face_valid;
    in_ch.end_of_frame <= f.end_of_frame;
    in_ch.box_left     <= f.left_x;
    in_ch.box_top      <= f.top_y;
    in_ch.box_right    <= f.right_x;
    in_ch.box_bottom   <= f.bottom_y;
    in_ch.gender_class <= f.gender;
    in_ch.age_class    <= f.age;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    if (f.face_valid || f.end_of_frame) sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // wait for all owed totals, then let a non-eof item finish inside the block
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // the face that random frames follow; mostly small, now and then huge or at an edge
  task automatic new_anchor();
    if ($urandom_range(19) == 0) begin
      anc_w = $urandom_range(1, CMAX);
      anc_h = $urandom_range(1, CMAX);
    end else begin
      anc_w = $urandom_range(1, 300);
      anc_h = $urandom_range(1, 300);
    end
    anc_l = $urandom_range(0, CMAX - anc_w);
    anc_t = $urandom_range(0, CMAX - anc_h);
    if ($urandom_range(9) == 0) anc_l = $urandom_range(1) ? 0 : CMAX - anc_w;
    if ($urandom_range(9) == 0) anc_t = $urandom_range(1) ? 0 : CMAX - anc_h;
    anc_g = $urandom_range(1);
    anc_a = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(4);
  endtask

  task automatic random_frame();
    int kind, n, pick, jx, jy, l, t, w, h, g, a;
    logic eof;
    kind = $urandom_range(99);
    if (kind < 12) begin
      // run of empty frames, at times long enough to drop the track
      n = $urandom_range(1, cur_miss + 2);
      repeat (n) begin
        if ($urandom_range(3) == 0) send_face(random_face(1'b0, 1'b0));
        send_face(random_face(1'b0, 1'b1));
      end
    end else begin
      if (kind < 22) new_anchor();
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        eof  = (i == n - 1);
        pick = $urandom_range(99);
        g = ($urandom_range(99) < 80) ? anc_g : int'($urandom_range(1));
        a = ($urandom_range(99) < 70) ? anc_a : int'($urandom_range(7));
        jx = anc_w / 4 + 1;
        jy = anc_h / 4 + 1;
        l = anc_l + int'($urandom_range(2 * jx)) - jx;
        t = anc_t + int'($urandom_range(2 * jy)) - jy;
        w = anc_w + int'($urandom_range(2 * jx)) - jx;
        h = anc_h + int'($urandom_range(2 * jy)) - jy;
        if (pick < 8) begin
          send_face(random_face(1'b0, eof));
        end else if (pick < 20) begin
          send_face(random_face(1'b1, eof));
        end else begin
          // smaller bystander near the tracked face
          if (pick < 35) begin
            w = w / 2;
            h = h / 2;
          end
          // now and then an inverted box
          if ($urandom_range(32) == 0) begin
            l  = l + w;
            w  = -w;
          end
          send_face(make_face(1'b1, eof, l, t, l + w, t + h, g, a));
        end
      end
      // drift the tracked face a little
      anc_l = clamp(anc_l + int'($urandom_range(8)) - 4);
      anc_t = clamp(anc_t + int'($urandom_range(8)) - 4);
    end
  endtask

  initial begin
    int iou_set [PHASES];
    int miss_set [PHASES];
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.face_valid   = 1'b0;
    in_ch.end_of_frame = 1'b0;
    in_ch.box_left     = '0;
    in_ch.box_top      = '0;
    in_ch.box_right    = '0;
    in_ch.box_bottom   = '0;
    in_ch.gender_class = 1'b0;
    in_ch.age_class    = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_IOU_TENTHS;
    cfg_ch.data        = '0;
    sent               = 0;
    cur_miss           = MISS_LIMIT_RST;
    iou_set  = '{0, 10, 15, 3, 1, 5, 9, 0};
    miss_set = '{0, 15, 2, 1, 0, 3, 7, 0};
    iou_set[PHASES-1]  = $urandom_range(15);
    miss_set[PHASES-1] = $urandom_range(15);
    new_anchor();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed frames under reset register values
    send_face(make_face(1'b0, 1'b1, 0, 0, 0, 0, 0, 0));             // empty, no track
    send_face(make_face(1'b1, 1'b1, 0, 0, 100, 100, 0, 0));         // opens the track
    send_face(make_face(1'b1, 1'b1, 10, 10, 110, 110, 1, 4));       // match, votes now tied
    send_face(make_face(1'b1, 1'b0, 2000, 2000, 2100, 2100, 1, 2)); // equal areas: first wins
    send_face(make_face(1'b1, 1'b1, 0, 0, 100, 100, 0, 3));         // miss -> replace on ties
    send_face(make_face(1'b1, 1'b0, 2000, 2000, 2050, 2050, 0, 1));
    send_face(make_face(1'b1, 1'b1, 2010, 2010, 2110, 2110, 0, 1)); // larger face on eof item
    send_face(make_face(1'b1, 1'b1, CMAX, CMAX, 0, 0, 1, 7));       // inverted, age clamped
    send_face(make_face(1'b1, 1'b1, CMAX, 0, 0, CMAX, 0, 5));       // zero union, no match
    send_face(make_face(1'b1, 1'b1, 0, 0, CMAX, CMAX, 1, 6));       // full-size box
    send_face(make_face(1'b1, 1'b1, 0, 0, CMAX, CMAX, 0, 4));       // identical box matches
    send_face(make_face(1'b0, 1'b0, CMAX, CMAX, CMAX, CMAX, 1, 7)); // non-face, ignored
    send_face(make_face(1'b0, 1'b1, CMAX, CMAX, CMAX, CMAX, 1, 7)); // first miss tolerated
    send_face(make_face(1'b0, 1'b1, 0, 0, 0, 0, 0, 0));             // second miss drops track
    send_face(make_face(1'b0, 1'b1, 0, 0, 0, 0, 0, 0));             // stays idle
    send_face(make_face(1'b1, 1'b0, 0, CMAX, CMAX, 0, 1, 2));       // inverted in y only
    send_face(make_face(1'b1, 1'b1, 100, 100, 200, 200, 1, 2));
    drain();

    // random phases, each with its own registers and idle pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_IOU_TENTHS, CFG_DATA_BITS'(iou_set[ph]));
      write_reg(REG_MISS_LIMIT, CFG_DATA_BITS'(miss_set[ph]));
      cfg_ch.valid <= 1'b0;
      cur_miss = miss_set[ph];
      case (ph % 4)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle  = 72;
          recv_stall = 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 72;
        end
        default: begin
          send_idle  = 19;
          recv_stall = 19;
        end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) random_frame();
      drain();
    end

    if (fail_count == 0) begin
      $display("iou_face_track_counter_test passed");
    end else begin
      $display("iou_face_track_counter_test failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/iftc_pkg.sv
hdl/iftc_in_if.sv
hdl/iftc_out_if.sv
hdl/iftc_cfg_if.sv
hdl/iftc_ctrl.sv
hdl/iftc_dp.sv
hdl/iou_face_track_counter.sv
tb/sv/iou_face_track_counter_check.sv
tb/sv/iou_face_track_counter_test.sv
